/* rtl/core/slip_stream_deframer_assert.svh */
// Assertion macros used by the deframer checker.
`ifndef SLIP_STREAM_DEFRAMER_ASSERT_SVH
`define SLIP_STREAM_DEFRAMER_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define SSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also covers the reset cycles.
`define SSD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/ssd_pkg.sv */
// Shared types and constants of the SLIP stream deframer.
`default_nettype none
package ssd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [BYTE_W-1:0] END_BYTE_RST     = 8'd192;
  localparam logic [BYTE_W-1:0] ESC_BYTE_RST     = 8'd219;
  localparam logic [BYTE_W-1:0] ESC_END_CODE_RST = 8'd220;
  localparam logic [BYTE_W-1:0] ESC_ESC_CODE_RST = 8'd221;

  typedef enum logic [1:0] {
    CFG_END_BYTE     = 2'd0,
    CFG_ESC_BYTE     = 2'd1,
    CFG_ESC_END_CODE = 2'd2,
    CFG_ESC_ESC_CODE = 2'd3
  } cfg_addr_t;

  typedef struct packed {
    logic [BYTE_W-1:0] end_byte;
    logic [BYTE_W-1:0] esc_byte;
    logic [BYTE_W-1:0] esc_end_code;
    logic [BYTE_W-1:0] esc_esc_code;
  } cfg_t;

  // Classified raw word handed from the front to the back.
  typedef struct packed {
    logic [BYTE_W-1:0] raw;
    logic              is_end;
    logic              is_esc;
    logic              is_esc_end;
    logic              is_esc_esc;
  } tok_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_sts_t;

endpackage
`default_nettype wire

/* rtl/core/slip_stream_deframer.sv */
// A raw word is registered in the queue; its result word is registered in the output register.
// Throughput: one raw word per cycle while the output is not stalled, set by the two-entry queue
// between the classifying front and the unstuffing back feeding the output register.
// Reset (rst_n low, synchronous): frame flags, queue and output valid clear,
// and the four framing codes return to 192, 219, 220 and 221.
`default_nettype none
module slip_stream_deframer (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [ssd_pkg::BYTE_W-1:0]   in_tdata,   // [7:0] raw_byte
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [ssd_pkg::BYTE_W-1:0]   out_tdata,  // [7:0] data_byte
  output logic                         out_tlast,  // frame_end
  output logic                         out_tuser,  // [0] frame_bad
  input  wire                          cfg_we,
  input  wire  [1:0]                   cfg_addr,
  input  wire  [ssd_pkg::BYTE_W-1:0]   cfg_wdata
);

  ssd_pkg::cfg_t   cfg_r;
  ssd_pkg::q_ctl_t q_ctl;
  ssd_pkg::q_sts_t q_sts;
  ssd_pkg::tok_t   wr_tok;
  ssd_pkg::tok_t   rd_tok;
  logic            push;
  logic            pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.end_byte     <= ssd_pkg::END_BYTE_RST;
      cfg_r.esc_byte     <= ssd_pkg::ESC_BYTE_RST;
      cfg_r.esc_end_code <= ssd_pkg::ESC_END_CODE_RST;
      cfg_r.esc_esc_code <= ssd_pkg::ESC_ESC_CODE_RST;
    end else if (cfg_we) begin
      unique case (ssd_pkg::cfg_addr_t'(cfg_addr))
        ssd_pkg::CFG_END_BYTE:     cfg_r.end_byte     <= cfg_wdata;
        ssd_pkg::CFG_ESC_BYTE:     cfg_r.esc_byte     <= cfg_wdata;
        ssd_pkg::CFG_ESC_END_CODE: cfg_r.esc_end_code <= cfg_wdata;
        ssd_pkg::CFG_ESC_ESC_CODE: cfg_r.esc_esc_code <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign q_ctl.push = push;
  assign q_ctl.pop  = pop;

  ssd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg       (cfg_r),
    .q_full    (q_sts.full),
    .push      (push),
    .tok       (wr_tok)
  );

  ssd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (q_ctl),
    .wr_tok (wr_tok),
    .rd_tok (rd_tok),
    .sts    (q_sts)
  );

  ssd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .end_byte   (cfg_r.end_byte),
    .esc_byte   (cfg_r.esc_byte),
    .q_valid    (q_sts.valid),
    .tok        (rd_tok),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

/* rtl/core/ssd_front.sv */
// Front end: accepts raw words and classifies them against the framing codes.
`default_nettype none
module ssd_front (
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [ssd_pkg::BYTE_W-1:0]       in_tdata,   // [7:0] raw_byte
  input  ssd_pkg::cfg_t                    cfg,
  input  wire                              q_full,
  output logic                             push,
  output ssd_pkg::tok_t                    tok
);

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_comb begin
    tok.raw        = in_tdata;
    tok.is_end     = (in_tdata == cfg.end_byte);
    tok.is_esc     = (in_tdata == cfg.esc_byte);
    tok.is_esc_end = (in_tdata == cfg.esc_end_code);
    tok.is_esc_esc = (in_tdata == cfg.esc_esc_code);
  end

endmodule
`default_nettype wire

/* rtl/core/ssd_queue.sv */
// Short register queue of classified words between front and back.
`default_nettype none
module ssd_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  ssd_pkg::q_ctl_t    ctl,
  input  ssd_pkg::tok_t      wr_tok,
  output ssd_pkg::tok_t      rd_tok,
  output ssd_pkg::q_sts_t    sts
);

  ssd_pkg::tok_t                   mem_r [ssd_pkg::Q_DEPTH];
  logic [ssd_pkg::Q_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ssd_pkg::Q_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ssd_pkg::Q_CNT_W-1:0]     count_r, count_nxt;

  function automatic logic [ssd_pkg::Q_PTR_W-1:0] ptr_inc(
    input logic [ssd_pkg::Q_PTR_W-1:0] p
  );
    if (p == ssd_pkg::Q_PTR_W'(ssd_pkg::Q_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign sts.valid = (count_r != '0);
  assign sts.full  = (count_r == ssd_pkg::Q_CNT_W'(ssd_pkg::Q_DEPTH));
  assign rd_tok    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = ctl.push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = ctl.pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (ctl.push && !ctl.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!ctl.push && ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[wr_ptr_r] <= wr_tok;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ssd_back.sv */
// Back end: frame state, unstuffing and the registered result word.
`default_nettype none
module ssd_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  [ssd_pkg::BYTE_W-1:0]   end_byte,
  input  wire  [ssd_pkg::BYTE_W-1:0]   esc_byte,
  input  wire                          q_valid,
  input  ssd_pkg::tok_t                tok,
  output logic                         pop,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [ssd_pkg::BYTE_W-1:0]   out_tdata,  // [7:0] data_byte
  output logic                         out_tlast,  // frame_end
  output logic                         out_tuser   // [0] frame_bad
);

  logic esc_pend_r, esc_pend_nxt;
  logic raw_seen_r, raw_seen_nxt;
  logic bad_seen_r, bad_seen_nxt;
  logic any_dec_r,  any_dec_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [ssd_pkg::BYTE_W-1:0]  data_r;
  logic                        last_r, bad_r;

  logic                        emit;
  logic [ssd_pkg::BYTE_W-1:0]  emit_data;
  logic                        emit_last, emit_bad;

  // Take the next word whenever the result register is free or draining.
  assign pop = q_valid && (!out_valid_r || out_tready);

  always_comb begin
    esc_pend_nxt = esc_pend_r;
    raw_seen_nxt = raw_seen_r;
    bad_seen_nxt = bad_seen_r;
    any_dec_nxt  = any_dec_r;
    emit         = 1'b0;
    emit_data    = tok.raw;
    emit_last    = 1'b0;
    emit_bad     = 1'b0;
    if (pop) begin
      if (tok.is_end) begin
        // Delimiter with nothing since the last one: drop.
        if (raw_seen_r) begin
          emit         = 1'b1;
          emit_data    = '0;
          emit_last    = 1'b1;
          emit_bad     = bad_seen_r || !any_dec_r;
          esc_pend_nxt = 1'b0;
          raw_seen_nxt = 1'b0;
          bad_seen_nxt = 1'b0;
          any_dec_nxt  = 1'b0;
        end
      end else begin
        raw_seen_nxt = 1'b1;
        if (bad_seen_r) begin
          esc_pend_nxt = 1'b0;
        end else if (esc_pend_r) begin
          esc_pend_nxt = 1'b0;
          if (tok.is_esc_end) begin
            emit        = 1'b1;
            emit_data   = end_byte;
            any_dec_nxt = 1'b1;
          end else if (tok.is_esc_esc) begin
            emit        = 1'b1;
            emit_data   = esc_byte;
            any_dec_nxt = 1'b1;
          end else begin
            bad_seen_nxt = 1'b1;
          end
        end else if (tok.is_esc) begin
          esc_pend_nxt = 1'b1;
        end else begin
          emit        = 1'b1;
          any_dec_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = emit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_pend_r  <= 1'b0;
      raw_seen_r  <= 1'b0;
      bad_seen_r  <= 1'b0;
      any_dec_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      esc_pend_r  <= esc_pend_nxt;
      raw_seen_r  <= raw_seen_nxt;
      bad_seen_r  <= bad_seen_nxt;
      any_dec_r   <= any_dec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      data_r <= emit_data;
      last_r <= emit_last;
      bad_r  <= emit_bad;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = bad_r;

endmodule
`default_nettype wire

/* rtl/core/ssd_checker.sv */
// Port-level checks of the deframer, bound to the top level.
`default_nettype none
`include "slip_stream_deframer_assert.svh"
module ssd_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_tready,
  input wire                          out_tvalid,
  input wire                          out_tready,
  input wire [ssd_pkg::BYTE_W-1:0]    out_tdata,
  input wire                          out_tlast,
  input wire                          out_tuser
);

  logic                         stall;
  logic [ssd_pkg::BYTE_W+1:0]   out_word;

  assign stall    = out_tvalid && !out_tready;
  assign out_word = {out_tdata, out_tlast, out_tuser};

  `SSD_ASSERT(a_end_word_zero, out_tvalid && out_tlast |-> out_tdata == '0, "end word data")
  `SSD_ASSERT(a_data_not_bad, out_tvalid && !out_tlast |-> !out_tuser, "data word flagged bad")
  `SSD_ASSERT(a_out_hold, stall |=> out_tvalid && $stable(out_word), "stalled word changed")
  `SSD_ASSERT_RST(a_rst_clear, !rst_n |=> !out_tvalid && in_tready, "output busy after reset")

endmodule

bind slip_stream_deframer ssd_checker u_ssd_checker (.*);
`default_nettype wire

/* tb/testbench.sv */
// Testbench for the SLIP stream deframer: directed frames, code sweeps, random traffic, back-pressure.
`default_nettype none
module testbench;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 6;

  typedef logic [ssd_pkg::BYTE_W-1:0] byte_t;

  typedef struct {
    byte_t data;
    logic  last;
    logic  bad;
  } decoded_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  byte_t             in_tdata;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  byte_t             out_tdata;
  logic              out_tlast;
  logic              out_tuser;
  logic              cfg_we;
  logic [1:0]        cfg_addr;
  byte_t             cfg_wdata;

  // Predictor copy of the framing codes and the frame flags.
  ssd_pkg::cfg_t codes;
  logic esc_armed;
  logic in_frame;
  logic frame_broken;
  logic got_payload;

  decoded_t decoded_q[$];
  int       err_count = 0;
  int       bytes_sent = 0;
  int       cycle_count = 0;
  int       sender_gap_pct = 0;
  int       rx_stall_pct = 0;
  int       hold_req = 0;
  int       hold_ack = 0;
  int       hold_left = 0;

  slip_stream_deframer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] raw_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] data_byte
    .out_tlast  (out_tlast),  // frame_end
    .out_tuser  (out_tuser),  // [0] frame_bad
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    err_count++;
  endtask

  function automatic void push_decoded(input byte_t d, input logic l, input logic b);
    decoded_t w;
    w.data = d;
    w.last = l;
    w.bad  = b;
    decoded_q.push_back(w);
  endfunction

  // Unstuff one raw byte; queue the word it yields, if any.
  function automatic void unstuff_byte(input byte_t b);
    if (b == codes.end_byte) begin
      if (in_frame) begin
        push_decoded('0, 1'b1, frame_broken || !got_payload);
        esc_armed    = 1'b0;
        in_frame     = 1'b0;
        frame_broken = 1'b0;
        got_payload  = 1'b0;
      end
    end else begin
      in_frame = 1'b1;
      if (frame_broken) begin
        esc_armed = 1'b0;
      end else if (esc_armed) begin
        esc_armed = 1'b0;
        if (b == codes.esc_end_code) begin
          got_payload = 1'b1;
          push_decoded(codes.end_byte, 1'b0, 1'b0);
        end else if (b == codes.esc_esc_code) begin
          got_payload = 1'b1;
          push_decoded(codes.esc_byte, 1'b0, 1'b0);
        end else begin
          frame_broken = 1'b1;
        end
      end else if (b == codes.esc_byte) begin
        esc_armed = 1'b1;
      end else begin
        got_payload = 1'b1;
        push_decoded(b, 1'b0, 1'b0);
      end
    end
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    decoded_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected word data=%02h last=%0b bad=%0b",
                         out_tdata, out_tlast, out_tuser));
      end else begin
        w = decoded_q.pop_front();
        if (out_tdata !== w.data)
          report($sformatf("data %02h, want %02h", out_tdata, w.data));
        if (out_tlast !== w.last)
          report($sformatf("last %0b, want %0b", out_tlast, w.last));
        if (out_tuser !== w.bad)
          report($sformatf("bad %0b, want %0b", out_tuser, w.bad));
      end
    end
  end

  task automatic send_byte(input byte_t b);
    @(negedge clk);
    // Idle each cycle with the gap probability.
    while (sender_gap_pct > 0 && $urandom_range(99) < sender_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    unstuff_byte(b);
    bytes_sent++;
  endtask

  // Stop sending and let every queued word drain, then settle.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input ssd_pkg::cfg_addr_t a, input byte_t v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= v;
    case (a)
      ssd_pkg::CFG_END_BYTE:     codes.end_byte     = v;
      ssd_pkg::CFG_ESC_BYTE:     codes.esc_byte     = v;
      ssd_pkg::CFG_ESC_END_CODE: codes.esc_end_code = v;
      ssd_pkg::CFG_ESC_ESC_CODE: codes.esc_esc_code = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_codes(input byte_t e, input byte_t s, input byte_t ee, input byte_t es);
    write_reg(ssd_pkg::CFG_END_BYTE, e);
    write_reg(ssd_pkg::CFG_ESC_BYTE, s);
    write_reg(ssd_pkg::CFG_ESC_END_CODE, ee);
    write_reg(ssd_pkg::CFG_ESC_ESC_CODE, es);
  endtask

  // One frame with random content: mostly well formed, some noise.
  task automatic send_frame();
    int len;
    int r;
    int tries;
    byte_t b;
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(8);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 60) begin
        tries = 0;
        do begin
          b = byte_t'($urandom_range(255));
          tries++;
        end while ((b == codes.end_byte || b == codes.esc_byte) && tries < 16);
        send_byte(b);
      end else if (r < 78) begin
        send_byte(codes.esc_byte);
        send_byte(codes.esc_end_code);
      end else if (r < 92) begin
        send_byte(codes.esc_byte);
        send_byte(codes.esc_esc_code);
      end else if (r < 96) begin
        send_byte(codes.esc_byte);
        send_byte(byte_t'($urandom_range(255)));
      end else begin
        send_byte(byte_t'($urandom_range(255)));
      end
    end
    if ($urandom_range(19) == 0) send_byte(codes.esc_byte);
    send_byte(codes.end_byte);
    if ($urandom_range(19) == 0) send_byte(codes.end_byte);
  endtask

  task automatic send_frames(input int n);
    int stop_at;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) send_frame();
  endtask

  task automatic test_directed_frames();
    sender_gap_pct = 0;
    rx_stall_pct   = 0;
    // Empty frame, then plain bytes at the extremes.
    send_byte(codes.end_byte);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h55);
    send_byte(8'haa);
    send_byte(codes.end_byte);
    // Both escape codes.
    send_byte(codes.esc_byte);
    send_byte(codes.esc_end_code);
    send_byte(codes.esc_byte);
    send_byte(codes.esc_esc_code);
    send_byte(codes.end_byte);
    // Unknown escape code: drop the rest of the frame.
    send_byte(8'h01);
    send_byte(codes.esc_byte);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(codes.end_byte);
    // Dangling escape with nothing decoded: empty and bad.
    send_byte(codes.esc_byte);
    send_byte(codes.end_byte);
    // Dangling escape after payload.
    send_byte(8'h7e);
    send_byte(codes.esc_byte);
    send_byte(codes.end_byte);
    send_byte(codes.end_byte);
    wait_idle();
  endtask

  task automatic test_code_settings();
    sender_gap_pct = 11;
    rx_stall_pct   = 11;
    set_codes(8'h00, 8'hff, 8'h00, 8'hff);
    send_frames(60);
    wait_idle();
    set_codes(8'hff, 8'h00, 8'hff, 8'h00);
    send_frames(60);
    wait_idle();
    // Escape equal to delimiter: it acts as the delimiter.
    set_codes(8'h7e, 8'h7e, 8'h5e, 8'h5e);
    send_frames(60);
    wait_idle();
    // Equal escape codes: the code decodes to the delimiter.
    set_codes(8'h0a, 8'h5c, 8'h33, 8'h33);
    send_frames(60);
    wait_idle();
    set_codes(ssd_pkg::END_BYTE_RST, ssd_pkg::ESC_BYTE_RST,
              ssd_pkg::ESC_END_CODE_RST, ssd_pkg::ESC_ESC_CODE_RST);
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int n);
    sender_gap_pct = gap_pct;
    rx_stall_pct   = stall_pct;
    send_frames(n);
    wait_idle();
  endtask

  task automatic test_backpressure();
    sender_gap_pct = 0;
    rx_stall_pct   = 0;
    hold_req++;
    send_frames(60);
    // Pause until the backlog is gone, then go on.
    wait_idle();
    send_frames(20);
    wait_idle();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = ssd_pkg::CFG_END_BYTE;
    cfg_wdata = '0;
    codes.end_byte     = ssd_pkg::END_BYTE_RST;
    codes.esc_byte     = ssd_pkg::ESC_BYTE_RST;
    codes.esc_end_code = ssd_pkg::ESC_END_CODE_RST;
    codes.esc_esc_code = ssd_pkg::ESC_ESC_CODE_RST;
    esc_armed    = 1'b0;
    in_frame     = 1'b0;
    frame_broken = 1'b0;
    got_payload  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_code_settings();
    test_random_traffic(0, 0, 220);
    test_random_traffic(48, 0, 220);
    test_random_traffic(0, 48, 220);
    test_random_traffic(11, 11, 220);
    test_backpressure();

    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* slip_stream_deframer.f */
+incdir+rtl/core
rtl/core/ssd_pkg.sv
rtl/core/ssd_front.sv
rtl/core/ssd_queue.sv
rtl/core/ssd_back.sv
rtl/core/slip_stream_deframer.sv
rtl/core/ssd_checker.sv
tb/testbench.sv
